>>> rtl/core/thb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Terrain height brush package
// Item kinds, flatten targets, register indexes and small helpers shared by
// the modules of the terrain height brush.
// ---------------------------------------------------------------------------
package thb_pkg;

  typedef enum logic [2:0] {
    KIND_LOAD       = 3'd0,
    KIND_READ       = 3'd1,
    KIND_BRUSH_UP   = 3'd2,
    KIND_BRUSH_DOWN = 3'd3,
    KIND_NEAR_UP    = 3'd4,
    KIND_NEAR_DOWN  = 3'd5,
    KIND_FLATTEN    = 3'd6,
    KIND_NONE       = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    FLAT_LOW  = 2'd0,
    FLAT_HIGH = 2'd1,
    FLAT_MEAN = 2'd2,
    FLAT_KEEP = 2'd3
  } flat_mode_t;

  localparam logic [2:0] CFG_OFFSET_X = 3'd0;
  localparam logic [2:0] CFG_OFFSET_Y = 3'd1;
  localparam logic [2:0] CFG_OFFSET_Z = 3'd2;
  localparam logic [2:0] CFG_RADIUS   = 3'd3;
  localparam logic [2:0] CFG_POWER    = 3'd4;
  localparam logic [2:0] CFG_COUNT    = 3'd5;

  // Width of the brush power register, Q8.8.
  localparam int POWER_BITS = 16;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

>>> rtl/core/terrain_height_brush_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Terrain height brush
// Vertex store with brush, nearest-vertex and flatten tools.
// ---------------------------------------------------------------------------
// Each vertex visit reads the store, forms the squared distance and evaluates it;
// a brush vertex in the outer ring also takes a square root and a divide. Flatten
// makes a second pass to write the target, after a divide for the mean, except for
// an empty set or mode 3. Nearest ends with a fix of the chosen vertex, if found.
// One item at a time: busy is high from accept until the result strobe; the
// receiver cannot stall. Reset clears control and the configuration registers, not the store.
// ---------------------------------------------------------------------------
module terrain_height_brush_top #(
  parameter int VERTEX_DEPTH = 1024,
  parameter int COORD_BITS   = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  // Item channel.
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            kind,
  input  logic [9:0]            vertex_index,
  input  logic [COORD_BITS-1:0] pos_x,
  input  logic [COORD_BITS-1:0] pos_y,
  input  logic [COORD_BITS-1:0] pos_z,
  input  logic                  edge_flag,
  input  logic [1:0]            flatten_mode,
  // Result channel.
  output logic                  done,
  output logic [9:0]            result_index,
  output logic [COORD_BITS-1:0] result_z,
  output logic [10:0]           affected_count,
  output logic                  status,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [thb_pkg::imax(COORD_BITS, thb_pkg::POWER_BITS)-1:0] cfg_data
);

  localparam int CB   = COORD_BITS;
  localparam int PB   = thb_pkg::POWER_BITS;
  localparam int AW   = $clog2(VERTEX_DEPTH);
  localparam int CW   = AW + 1;
  localparam int WW   = 3 * CB + 1;
  localparam int DSW  = 2 * CB + 4;
  localparam int RW   = CB - 1;
  localparam int VW   = 2 * RW;
  localparam int PRW  = RW + PB;
  localparam int SW   = CB + AW + 1;
  localparam int DVW  = thb_pkg::imax(PRW, SW);
  localparam int DW   = thb_pkg::imax(RW, CW);
  localparam int CHW  = PB + 1;
  localparam int SZ   = thb_pkg::imax(CB, CHW) + 2;

  // The controller walks the store one vertex at a time. Every write back
  // of a vertex completes before the next read is issued, so a read never
  // overlaps a pending write to the same entry.
  typedef enum logic [10:0] {
    ST_IDLE     = 11'b00000000001,
    ST_PREP     = 11'b00000000010,
    ST_SCAN_RD  = 11'b00000000100,
    ST_SCAN_DAT = 11'b00000001000,
    ST_SCAN_D2  = 11'b00000010000,
    ST_SQRT     = 11'b00000100000,
    ST_DIV      = 11'b00001000000,
    ST_APPLY    = 11'b00010000000,
    ST_RD_OUT   = 11'b00100000000,
    ST_NEAR_FIX = 11'b01000000000,
    ST_MEAN     = 11'b10000000000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [CB-1:0] mesh_offset_x, mesh_offset_y, mesh_offset_z;
  logic [RW-1:0] brush_radius;
  logic [PB-1:0] brush_power;
  logic [10:0]   vertex_count;

  // Latched item.
  thb_pkg::kind_t      kind_q;
  thb_pkg::flat_mode_t mode_q;
  logic [9:0]          idx_q;
  logic [CB-1:0]       hx, hy, hz;
  logic                edge_q;
  // Range check of the latched slot index.
  logic                oob_q;

  // Per-item working registers.
  logic [VW-1:0]  r2;
  logic [PRW-1:0] pr;
  logic [CW-1:0]  n;
  logic [CW-1:0]  cur, cur_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic [CB-1:0]  lo, lo_next, hi, hi_next;
  logic [SW-1:0]  sum, sum_next;
  logic           found, found_next;
  logic [AW-1:0]  best, best_next;
  logic [DSW-1:0] bd, bd_next;
  logic           pass2, pass2_next;
  logic [CB-1:0]  target, target_next;
  logic [CHW-1:0] ch, ch_next;
  logic [WW-1:0]  vreg;

  // Store access.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WW-1:0] ram_wdata, ram_rdata;

  // Unit handshakes.
  logic           dist_go, d2_valid;
  logic [DSW-1:0] d2;
  logic           sq_start, sq_done;
  logic [RW-1:0]  sq_root;
  logic           div_start, div_done;
  logic [DVW-1:0] div_dividend, div_quotient;
  logic [DW-1:0]  div_divisor;

  // Result staging.
  logic          fin;
  logic [9:0]    res_index_next;
  logic [CB-1:0] res_z_next;
  logic [10:0]   res_count_next;
  logic          res_status_next;

  // Derived per-vertex values.
  logic          oob, last, elig, in_range, inner, brush_kind, near_kind;
  logic [CB-1:0] vz_cur, sat_z, sat_in;
  logic [CHW-1:0] sat_amt, two_p;
  logic          sat_sub;
  logic [SZ-1:0] sat_sum;
  logic [SW-1:0] sum_mag;
  logic [CB-1:0] mean_q;
  logic [CW-1:0] n_eff;

  assign busy = (state != ST_IDLE);

  // ---------------------------------------------------------------------
  // Configuration writes.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mesh_offset_x <= '0;
      mesh_offset_y <= '0;
      mesh_offset_z <= '0;
      brush_radius  <= '0;
      brush_power   <= '0;
      vertex_count  <= 11'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        thb_pkg::CFG_OFFSET_X: mesh_offset_x <= cfg_data[CB-1:0];
        thb_pkg::CFG_OFFSET_Y: mesh_offset_y <= cfg_data[CB-1:0];
        thb_pkg::CFG_OFFSET_Z: mesh_offset_z <= cfg_data[CB-1:0];
        thb_pkg::CFG_RADIUS:   brush_radius  <= cfg_data[RW-1:0];
        thb_pkg::CFG_POWER:    brush_power   <= cfg_data[PB-1:0];
        thb_pkg::CFG_COUNT:    vertex_count  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Store and arithmetic units.
  // ---------------------------------------------------------------------
  thb_ram #(
    .WIDTH (WW),
    .DEPTH (VERTEX_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Store word layout: edge mark, X, Y, Z from the top down.
  thb_dist #(
    .COORD_BITS (CB)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .go       (dist_go),
    .vx       (ram_rdata[3*CB-1:2*CB]),
    .vy       (ram_rdata[2*CB-1:CB]),
    .vz       (ram_rdata[CB-1:0]),
    .ox       (mesh_offset_x),
    .oy       (mesh_offset_y),
    .oz       (mesh_offset_z),
    .hx       (hx),
    .hy       (hy),
    .hz       (hz),
    .d2_valid (d2_valid),
    .d2       (d2)
  );

  thb_isqrt #(
    .VALUE_BITS (VW)
  ) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (d2[VW-1:0]),
    .done  (sq_done),
    .root  (sq_root)
  );

  thb_div #(
    .DIVIDEND_BITS (DVW),
    .DIVISOR_BITS  (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // ---------------------------------------------------------------------
  // Per-vertex decisions.
  // ---------------------------------------------------------------------
  assign oob   = {22'b0, vertex_index} >= 32'(VERTEX_DEPTH);
  assign n_eff = ({21'b0, vertex_count} > 32'(VERTEX_DEPTH)) ? CW'(VERTEX_DEPTH)
                                                              : CW'(vertex_count);
  assign last  = (cur + CW'(1)) >= n;
  assign elig  = !vreg[3*CB];
  assign vz_cur = vreg[CB-1:0];
  // A vertex is in range when its squared distance is within R*R; the inner
  // disc (half the radius) gets double power.
  assign in_range = d2 <= DSW'(r2);
  assign inner    = {d2, 2'b00} <= (DSW + 2)'(r2);
  assign brush_kind = (kind_q == thb_pkg::KIND_BRUSH_UP) ||
                      (kind_q == thb_pkg::KIND_BRUSH_DOWN);
  assign near_kind  = (kind_q == thb_pkg::KIND_NEAR_UP) ||
                      (kind_q == thb_pkg::KIND_NEAR_DOWN);
  assign two_p = {brush_power, 1'b0};

  // Saturating height update, shared by the brush write back and the
  // nearest-vertex fix.
  always_comb begin
    if (state == ST_NEAR_FIX) begin
      sat_in  = ram_rdata[CB-1:0];
      sat_amt = CHW'(brush_power);
      sat_sub = (kind_q == thb_pkg::KIND_NEAR_DOWN);
    end else begin
      sat_in  = vz_cur;
      sat_amt = ch;
      sat_sub = (kind_q == thb_pkg::KIND_BRUSH_DOWN);
    end
    if (sat_sub) begin
      sat_sum = {{(SZ-CB){sat_in[CB-1]}}, sat_in} - SZ'(sat_amt);
    end else begin
      sat_sum = {{(SZ-CB){sat_in[CB-1]}}, sat_in} + SZ'(sat_amt);
    end
    if ((&sat_sum[SZ-1:CB-1]) || !(|sat_sum[SZ-1:CB-1])) begin
      sat_z = sat_sum[CB-1:0];
    end else if (sat_sum[SZ-1]) begin
      sat_z = {1'b1, {(CB-1){1'b0}}};
    end else begin
      sat_z = {1'b0, {(CB-1){1'b1}}};
    end
  end

  // Mean of the flatten set: magnitude divided by the count, sign restored,
  // which truncates toward zero.
  assign sum_mag = sum_next[SW-1] ? (-sum_next) : sum_next;
  assign mean_q  = sum[SW-1] ? CB'(-div_quotient[CB-1:0]) : div_quotient[CB-1:0];

  always_comb begin
    if (kind_q == thb_pkg::KIND_FLATTEN) begin
      div_dividend = DVW'(sum_mag);
      div_divisor  = DW'(cnt_next);
    end else begin
      div_dividend = DVW'(pr);
      div_divisor  = DW'(sq_root);
    end
  end

  // ---------------------------------------------------------------------
  // Controller.
  // ---------------------------------------------------------------------
  always_comb begin
    state_next      = state;
    ram_we          = 1'b0;
    ram_waddr       = cur[AW-1:0];
    ram_wdata       = {vreg[WW-1:CB], sat_z};
    ram_re          = 1'b0;
    ram_raddr       = cur[AW-1:0];
    dist_go         = 1'b0;
    sq_start        = 1'b0;
    div_start       = 1'b0;
    fin             = 1'b0;
    res_index_next  = '0;
    res_z_next      = '0;
    res_count_next  = '0;
    res_status_next = 1'b0;
    cur_next        = cur;
    cnt_next        = cnt;
    lo_next         = lo;
    hi_next         = hi;
    sum_next        = sum;
    found_next      = found;
    best_next       = best;
    bd_next         = bd;
    pass2_next      = pass2;
    target_next     = target;
    ch_next         = ch;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_PREP;
        end
      end

      ST_SCAN_RD: begin
        ram_re     = 1'b1;
        state_next = ST_SCAN_DAT;
      end

      ST_SCAN_DAT: begin
        dist_go    = 1'b1;
        state_next = ST_SCAN_D2;
      end

      ST_SQRT: begin
        if (sq_done) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          ch_next    = (div_quotient > DVW'(two_p)) ? two_p : div_quotient[CHW-1:0];
          state_next = ST_APPLY;
        end
      end

      ST_RD_OUT: begin
        fin            = 1'b1;
        res_index_next = idx_q;
        res_z_next     = ram_rdata[CB-1:0];
        res_count_next = 11'd1;
        state_next     = ST_IDLE;
      end

      ST_NEAR_FIX: begin
        ram_we         = 1'b1;
        ram_waddr      = best;
        ram_wdata      = {ram_rdata[WW-1:CB], sat_z};
        fin            = 1'b1;
        res_index_next = 10'(best);
        res_z_next     = sat_z;
        res_count_next = 11'd1;
        state_next     = ST_IDLE;
      end

      ST_MEAN: begin
        if (div_done) begin
          target_next = mean_q;
          pass2_next  = 1'b1;
          cur_next    = '0;
          state_next  = ST_SCAN_RD;
        end
      end

      default: ;
    endcase

    // Item dispatch once the item registers are loaded.
    if (state == ST_PREP) begin
      cur_next = '0;
      unique case (kind_q)
        thb_pkg::KIND_LOAD: begin
          fin             = 1'b1;
          ram_we          = !oob_q;
          ram_waddr       = AW'(idx_q);
          ram_wdata       = {edge_q, hx, hy, hz};
          res_index_next  = idx_q;
          res_z_next      = oob_q ? '0 : hz;
          res_count_next  = oob_q ? 11'd0 : 11'd1;
          res_status_next = oob_q;
          state_next      = ST_IDLE;
        end
        thb_pkg::KIND_READ: begin
          if (oob_q) begin
            fin             = 1'b1;
            res_index_next  = idx_q;
            res_status_next = 1'b1;
            state_next      = ST_IDLE;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = AW'(idx_q);
            state_next = ST_RD_OUT;
          end
        end
        thb_pkg::KIND_NONE: begin
          fin        = 1'b1;
          state_next = ST_IDLE;
        end
        default: begin
          state_next = ST_SCAN_RD;
        end
      endcase
    end

    // Evaluation of one vertex once its squared distance is ready.
    if (state == ST_SCAN_D2 && d2_valid) begin
      if (brush_kind && elig && in_range) begin
        if (inner) begin
          ch_next    = two_p;
          state_next = ST_APPLY;
        end else begin
          sq_start   = 1'b1;
          state_next = ST_SQRT;
        end
      end else begin
        state_next = ST_SCAN_RD;
      end
      if (near_kind && elig && (!found || d2 <= bd)) begin
        found_next = 1'b1;
        bd_next    = d2;
        best_next  = cur[AW-1:0];
      end
      if (kind_q == thb_pkg::KIND_FLATTEN && elig && in_range) begin
        if (pass2) begin
          ram_we    = 1'b1;
          ram_wdata = {vreg[WW-1:CB], target};
        end else begin
          if (cnt == '0 || $signed(vz_cur) < $signed(lo)) begin
            lo_next = vz_cur;
          end
          if (cnt == '0 || $signed(vz_cur) > $signed(hi)) begin
            hi_next = vz_cur;
          end
          sum_next = sum + {{(SW-CB){vz_cur[CB-1]}}, vz_cur};
          cnt_next = cnt + CW'(1);
        end
      end
    end

    if (state == ST_APPLY) begin
      ram_we     = 1'b1;
      cnt_next   = cnt + CW'(1);
      state_next = ST_SCAN_RD;
    end

    // Step to the next vertex, or close the pass. An empty store closes the
    // pass straight from dispatch.
    if ((state == ST_SCAN_RD && 1'b0) ||
        (state_next == ST_SCAN_RD && (state == ST_SCAN_D2 || state == ST_APPLY)) ||
        (state == ST_PREP && state_next == ST_SCAN_RD)) begin
      if (state != ST_PREP && !last) begin
        cur_next = cur + CW'(1);
      end else if (state != ST_PREP || n_eff == '0) begin
        state_next = ST_IDLE;
        if (brush_kind) begin
          fin             = 1'b1;
          res_count_next  = 11'(cnt_next);
          res_status_next = (cnt_next == '0);
        end else if (near_kind) begin
          if (found_next) begin
            ram_re     = 1'b1;
            ram_raddr  = best_next;
            state_next = ST_NEAR_FIX;
          end else begin
            fin             = 1'b1;
            res_status_next = 1'b1;
          end
        end else if (pass2) begin
          fin            = 1'b1;
          res_z_next     = target;
          res_count_next = 11'(cnt_next);
        end else if (cnt_next == '0) begin
          fin             = 1'b1;
          res_status_next = 1'b1;
        end else if (mode_q == thb_pkg::FLAT_KEEP) begin
          fin            = 1'b1;
          res_count_next = 11'(cnt_next);
        end else if (mode_q == thb_pkg::FLAT_MEAN) begin
          div_start  = 1'b1;
          state_next = ST_MEAN;
        end else begin
          target_next = (mode_q == thb_pkg::FLAT_LOW) ? lo_next : hi_next;
          pass2_next  = 1'b1;
          cur_next    = '0;
          state_next  = ST_SCAN_RD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      kind_q <= thb_pkg::kind_t'(kind);
      mode_q <= thb_pkg::flat_mode_t'(flatten_mode);
      idx_q  <= vertex_index;
      oob_q  <= oob;
      hx     <= pos_x;
      hy     <= pos_y;
      hz     <= pos_z;
      edge_q <= edge_flag;
      cnt    <= '0;
      sum    <= '0;
      found  <= 1'b0;
      pass2  <= 1'b0;
      cur    <= '0;
    end else begin
      cnt    <= cnt_next;
      sum    <= sum_next;
      found  <= found_next;
      pass2  <= pass2_next;
      cur    <= cur_next;
    end
    if (state == ST_PREP) begin
      r2 <= brush_radius * brush_radius;
      pr <= brush_power * brush_radius;
      n  <= n_eff;
    end
    if (state == ST_SCAN_DAT) begin
      vreg <= ram_rdata;
    end
    lo     <= lo_next;
    hi     <= hi_next;
    best   <= best_next;
    bd     <= bd_next;
    target <= target_next;
    ch     <= ch_next;
    if (fin) begin
      result_index   <= res_index_next;
      result_z       <= res_z_next;
      affected_count <= res_count_next;
      status         <= res_status_next;
    end
  end

endmodule

>>> rtl/core/thb_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module thb_ram #(
  parameter int WIDTH = 73,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/thb_dist.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Squared distance pipeline
// Three stages: absolute axis differences, squares, then the sum.
// ---------------------------------------------------------------------------
module thb_dist #(
  parameter int COORD_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [COORD_BITS-1:0]     vx,
  input  logic [COORD_BITS-1:0]     vy,
  input  logic [COORD_BITS-1:0]     vz,
  input  logic [COORD_BITS-1:0]     ox,
  input  logic [COORD_BITS-1:0]     oy,
  input  logic [COORD_BITS-1:0]     oz,
  input  logic [COORD_BITS-1:0]     hx,
  input  logic [COORD_BITS-1:0]     hy,
  input  logic [COORD_BITS-1:0]     hz,
  output logic                      d2_valid,
  output logic [2*COORD_BITS+3:0]   d2
);

  localparam int CB  = COORD_BITS;
  localparam int ABW = CB + 1;
  localparam int SQW = 2 * ABW;
  localparam int DSW = 2 * CB + 4;

  logic [CB+1:0]   dx, dy, dz;
  logic [ABW-1:0]  ax, ay, az;
  logic [SQW-1:0]  sx, sy, sz;
  logic [2:0]      vld;

  // World position is the stored position plus the mesh offset.
  always_comb begin
    dx = {{2{hx[CB-1]}}, hx} - ({vx[CB-1], vx[CB-1], vx} + {ox[CB-1], ox[CB-1], ox});
    dy = {{2{hy[CB-1]}}, hy} - ({vy[CB-1], vy[CB-1], vy} + {oy[CB-1], oy[CB-1], oy});
    dz = {{2{hz[CB-1]}}, hz} - ({vz[CB-1], vz[CB-1], vz} + {oz[CB-1], oz[CB-1], oz});
  end

  always_ff @(posedge clk) begin
    ax <= dx[CB+1] ? ABW'(-dx) : dx[ABW-1:0];
    ay <= dy[CB+1] ? ABW'(-dy) : dy[ABW-1:0];
    az <= dz[CB+1] ? ABW'(-dz) : dz[ABW-1:0];
    sx <= ax * ax;
    sy <= ay * ay;
    sz <= az * az;
    d2 <= DSW'(sx) + DSW'(sy) + DSW'(sz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], go};
    end
  end

  assign d2_valid = vld[2];

endmodule

>>> rtl/core/thb_isqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Integer square root
// Digit-by-digit root rounded down, one result bit per cycle.
// ---------------------------------------------------------------------------
module thb_isqrt #(
  parameter int VALUE_BITS = 46
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [VALUE_BITS-1:0]   value,
  output logic                    done,
  output logic [VALUE_BITS/2-1:0] root
);

  localparam int VW    = VALUE_BITS;
  localparam int STEPS = VW / 2;
  localparam int NW    = $clog2(STEPS + 1);

  logic [VW-1:0] v, r, b;
  logic [VW-1:0] t;
  logic [NW-1:0] steps_left;
  logic          running;

  assign t    = r + b;
  assign root = r[STEPS-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      v <= value;
      r <= '0;
      b <= VW'(1) << (VW - 2);
    end else if (running) begin
      if (v >= t) begin
        v <= v - t;
        r <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b <= b >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      done       <= 1'b0;
      steps_left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running    <= 1'b1;
        steps_left <= NW'(STEPS);
      end else if (running) begin
        steps_left <= steps_left - NW'(1);
        if (steps_left == NW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/thb_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Unsigned divider
// Restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module thb_div #(
  parameter int DIVIDEND_BITS = 39,
  parameter int DIVISOR_BITS  = 23
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic                     done,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  localparam int N  = DIVIDEND_BITS;
  localparam int D  = DIVISOR_BITS;
  localparam int NW = $clog2(N + 1);

  logic [D-1:0]  rem, den;
  logic [D:0]    trial;
  logic          take;
  logic [NW-1:0] steps_left;
  logic          running;

  assign trial = {rem, quotient[N-1]};
  assign take  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (running) begin
      rem      <= take ? D'(trial - {1'b0, den}) : trial[D-1:0];
      quotient <= {quotient[N-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      done       <= 1'b0;
      steps_left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running    <= 1'b1;
        steps_left <= NW'(N);
      end else if (running) begin
        steps_left <= steps_left - NW'(1);
        if (steps_left == NW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule
